// ===== rtl/tpr_pkg.sv =====
`timescale 1ns / 1ps

package tpr_pkg;

  // Widths of the command and result fields.
  localparam int FuncW    = 3;
  localparam int DistW    = 8;
  localparam int RowBitsW = 64;
  localparam int RowIdxW  = 6;

  // Command codes. Codes six and seven are ignored.
  localparam logic [FuncW-1:0] CMD_PEN_DOWN = 3'd0;
  localparam logic [FuncW-1:0] CMD_PEN_UP   = 3'd1;
  localparam logic [FuncW-1:0] CMD_LEFT     = 3'd2;
  localparam logic [FuncW-1:0] CMD_RIGHT    = 3'd3;
  localparam logic [FuncW-1:0] CMD_FORWARD  = 3'd4;
  localparam logic [FuncW-1:0] CMD_PRINT    = 3'd5;

  // Heading codes.
  localparam logic [1:0] HEAD_POS_X = 2'd0;
  localparam logic [1:0] HEAD_POS_Y = 2'd1;
  localparam logic [1:0] HEAD_NEG_X = 2'd2;
  localparam logic [1:0] HEAD_NEG_Y = 2'd3;

endpackage

// ===== rtl/turtle_plotter_raster_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                                    Handshake
// command   in         func_i, distance_i                       start high while busy low
// row       out        row_bits_o, row_index_o, last_o          result_valid_o, one cycle
//
// Pen and turn commands never raise busy.
// In a forward move each marked cell is a read and a write back through the canvas read and
// write ports, so steps are interlocked.
// Print holds busy while it reads the rows out in ascending order of y.
// Reset clears per-row valid bits at once, so no clearing pass is needed after reset.
// Rows cannot be stalled: each one is shown for exactly one cycle.
module turtle_plotter_raster_core #(
  parameter int GRID_SIZE = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic [tpr_pkg::FuncW-1:0]      func_i,
  input  logic [tpr_pkg::DistW-1:0]      distance_i,
  output logic                           busy,
  output logic                           result_valid_o,
  output logic [tpr_pkg::RowBitsW-1:0]   row_bits_o,
  output logic [tpr_pkg::RowIdxW-1:0]    row_index_o,
  output logic                           last_o
);
  import tpr_pkg::*;

  localparam int CW = $clog2(GRID_SIZE);
  localparam logic [CW-1:0] MaxPos = CW'(GRID_SIZE - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STEP  = 2'd1;
  localparam logic [1:0] ST_MARK  = 2'd2;
  localparam logic [1:0] ST_PRINT = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CW-1:0]        pos_x_q, pos_x_d;
  logic [CW-1:0]        pos_y_q, pos_y_d;
  logic [1:0]           heading_q, heading_d;
  logic                 pen_q, pen_d;
  logic [DistW-1:0]     steps_q, steps_d;
  logic [CW-1:0]        y_q, y_d;

  logic                 res_valid_q, res_valid_d;
  logic [CW-1:0]        res_idx_q, res_idx_d;
  logic                 res_last_q, res_last_d;

  logic [GRID_SIZE-1:0] canvas_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_valid_q;
  logic [GRID_SIZE-1:0] rd_q;
  logic                 rd_valid_q;
  logic [GRID_SIZE-1:0] cur_row;

  logic                 mem_re, mem_we;
  logic [CW-1:0]        raddr, waddr;
  logic [GRID_SIZE-1:0] wdata;

  logic                 accept;
  logic                 blocked;
  logic [CW-1:0]        nx, ny;

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign cur_row = rd_q & {GRID_SIZE{rd_valid_q}};

  // Next cell in the current heading, and whether the grid edge blocks it.
  always_comb begin
    nx      = pos_x_q;
    ny      = pos_y_q;
    blocked = 1'b0;
    unique case (heading_q)
      HEAD_POS_X: begin
        blocked = (pos_x_q == MaxPos);
        nx      = pos_x_q + 1'b1;
      end
      HEAD_POS_Y: begin
        blocked = (pos_y_q == MaxPos);
        ny      = pos_y_q + 1'b1;
      end
      HEAD_NEG_X: begin
        blocked = (pos_x_q == '0);
        nx      = pos_x_q - 1'b1;
      end
      HEAD_NEG_Y: begin
        blocked = (pos_y_q == '0);
        ny      = pos_y_q - 1'b1;
      end
    endcase
  end

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    heading_d   = heading_q;
    pen_d       = pen_q;
    steps_d     = steps_q;
    y_d         = y_q;
    res_valid_d = 1'b0;
    res_idx_d   = res_idx_q;
    res_last_d  = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    raddr       = y_q;
    waddr       = pos_y_q;
    wdata       = cur_row | (GRID_SIZE'(1) << pos_x_q);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            CMD_PEN_DOWN: pen_d     = 1'b1;
            CMD_PEN_UP:   pen_d     = 1'b0;
            CMD_LEFT:     heading_d = heading_q - 2'd1;
            CMD_RIGHT:    heading_d = heading_q + 2'd1;
            CMD_FORWARD: begin
              steps_d = distance_i;
              state_d = ST_STEP;
            end
            CMD_PRINT: begin
              y_d     = '0;
              state_d = ST_PRINT;
            end
            default: ;
          endcase
        end
      end
      ST_STEP: begin
        if (steps_q == '0 || blocked) begin
          state_d = ST_IDLE;
        end else begin
          pos_x_d = nx;
          pos_y_d = ny;
          steps_d = steps_q - 1'b1;
          if (pen_q) begin
            mem_re  = 1'b1;
            raddr   = ny;
            state_d = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        // The row read last cycle comes back; set the cell and write it back.
        mem_we  = 1'b1;
        state_d = ST_STEP;
      end
      ST_PRINT: begin
        mem_re      = 1'b1;
        res_valid_d = 1'b1;
        res_idx_d   = y_q;
        res_last_d  = (y_q == MaxPos);
        if (y_q == MaxPos) begin
          state_d = ST_IDLE;
        end else begin
          y_d = y_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and turtle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= HEAD_POS_X;
      pen_q       <= 1'b0;
      steps_q     <= '0;
      y_q         <= '0;
      res_valid_q <= 1'b0;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      heading_q   <= heading_d;
      pen_q       <= pen_d;
      steps_q     <= steps_d;
      y_q         <= y_d;
      res_valid_q <= res_valid_d;
      if (mem_we) begin
        row_valid_q[waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_valid_q <= row_valid_q[raddr];
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    res_idx_q  <= res_idx_d;
    res_last_q <= res_last_d;
  end

  // Canvas memory, one row per entry; a row never written reads as zero.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      canvas_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_q <= canvas_mem[raddr];
    end
  end

  assign result_valid_o = res_valid_q;
  assign row_bits_o     = RowBitsW'(cur_row);
  assign row_index_o    = RowIdxW'(res_idx_q);
  assign last_o         = res_last_q;

endmodule

// ===== rtl/tpr_checker.sv =====
`timescale 1ns / 1ps

module tpr_checker #(
  parameter int GRID_SIZE = 64
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [tpr_pkg::FuncW-1:0]   func_i,
  input logic                        result_valid_o,
  input logic [tpr_pkg::RowIdxW-1:0] row_index_o,
  input logic                        last_o
);
  import tpr_pkg::*;

  // A print beat starts the row burst at row zero.
  a_print_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && func_i == CMD_PRINT |-> ##2 result_valid_o && row_index_o == '0)
    else $error("print did not start with row zero");

  // Rows of a burst come back to back in ascending order until the last one.
  a_rows_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=>
      result_valid_o && row_index_o == RowIdxW'($past(row_index_o) + 1'b1))
    else $error("row burst broken or out of order");

  // The last marker only rides a valid beat, on the top row.
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o && row_index_o == RowIdxW'(GRID_SIZE - 1))
    else $error("last marker on the wrong row");

  // Pen and turn commands finish in their own cycle.
  a_quick_cmds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (func_i == CMD_PEN_DOWN || func_i == CMD_PEN_UP ||
                       func_i == CMD_LEFT || func_i == CMD_RIGHT) |=> !busy)
    else $error("pen or turn command raised busy");

endmodule

bind turtle_plotter_raster_core tpr_checker #(
  .GRID_SIZE(GRID_SIZE)
) u_tpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .func_i         (func_i),
  .result_valid_o (result_valid_o),
  .row_index_o    (row_index_o),
  .last_o         (last_o)
);

// ===== test/turtle_plotter_raster_checker.sv =====
`timescale 1ns / 1ps

// Watches the command and row channels of the raster core, keeps its own copy
// of the turtle and the bitmap, and compares every row beat with the oldest row
// that a print command has left waiting.
module turtle_plotter_raster_checker #(
  parameter int GRID_SIZE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic [tpr_pkg::FuncW-1:0]    func_i,
  input  logic [tpr_pkg::DistW-1:0]    distance_i,
  input  logic                         busy,
  input  logic                         result_valid_o,
  input  logic [tpr_pkg::RowBitsW-1:0] row_bits_o,
  input  logic [tpr_pkg::RowIdxW-1:0]  row_index_o,
  input  logic                         last_o,
  output int                           errors_o,
  output int                           rows_pending_o,
  output int                           rows_checked_o
);
  import tpr_pkg::*;

  typedef struct packed {
    logic [RowBitsW-1:0] bits;
    logic [RowIdxW-1:0]  index;
    logic                last;
  } plot_row_t;

  // Shadow copy of the plotter state.
  logic [RowBitsW-1:0] bitmap [GRID_SIZE];
  logic [5:0]          turtle_x;
  logic [5:0]          turtle_y;
  logic [1:0]          turtle_heading;
  logic                pen_is_down;

  plot_row_t printed_rows [$];
  plot_row_t oldest_row;
  int        mismatches;
  int        rows_compared;

  assign errors_o       = mismatches;
  assign rows_checked_o = rows_compared;

  // Walk one cell at a time; the first step that would leave the grid ends the move.
  task automatic walk_turtle(input int unsigned cells);
    int unsigned step;
    int          nx;
    int          ny;
    logic        blocked;
    blocked = 1'b0;
    for (step = 0; step < cells && !blocked; step++) begin
      nx = int'(turtle_x);
      ny = int'(turtle_y);
      case (turtle_heading)
        HEAD_POS_X: if (nx + 1 >= GRID_SIZE) blocked = 1'b1; else nx++;
        HEAD_POS_Y: if (ny + 1 >= GRID_SIZE) blocked = 1'b1; else ny++;
        HEAD_NEG_X: if (nx == 0) blocked = 1'b1; else nx--;
        default:    if (ny == 0) blocked = 1'b1; else ny--;
      endcase
      if (!blocked) begin
        turtle_x = nx[5:0];
        turtle_y = ny[5:0];
        if (pen_is_down) begin
          bitmap[ny][nx] = 1'b1;
        end
      end
    end
  endtask

  // Apply one accepted command; a print queues one row per y, lowest y first.
  task automatic plot_command(input logic [FuncW-1:0] code, input logic [DistW-1:0] cells);
    plot_row_t row;
    case (code)
      CMD_PEN_DOWN: pen_is_down = 1'b1;
      CMD_PEN_UP:   pen_is_down = 1'b0;
      CMD_LEFT:     turtle_heading = turtle_heading - 2'd1;
      CMD_RIGHT:    turtle_heading = turtle_heading + 2'd1;
      CMD_FORWARD:  walk_turtle(cells);
      CMD_PRINT: begin
        for (int y = 0; y < GRID_SIZE; y++) begin
          row.bits  = bitmap[y];
          row.index = y[RowIdxW-1:0];
          row.last  = (y == GRID_SIZE - 1);
          printed_rows.push_back(row);
        end
      end
      default: ;
    endcase
  endtask

  // Compare row beats first, then take in the command beat of this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int y = 0; y < GRID_SIZE; y++) begin
        bitmap[y] = '0;
      end
      turtle_x       = '0;
      turtle_y       = '0;
      turtle_heading = HEAD_POS_X;
      pen_is_down    = 1'b0;
      printed_rows.delete();
      mismatches     = 0;
      rows_compared  = 0;
      rows_pending_o <= 0;
    end else begin
      if (result_valid_o) begin
        if (printed_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: row beat with nothing expected: index %0d bits %h last %0b",
                     $time, row_index_o, row_bits_o, last_o);
          end
        end else begin
          oldest_row = printed_rows.pop_front();
          rows_compared++;
          if (oldest_row.bits !== row_bits_o || oldest_row.index !== row_index_o ||
              oldest_row.last !== last_o) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: row mismatch: expected index %0d bits %h last %0b", $time,
                       oldest_row.index, oldest_row.bits, oldest_row.last);
              $display("%t:                    got index %0d bits %h last %0b", $time,
                       row_index_o, row_bits_o, last_o);
            end
          end
        end
      end
      if (start && !busy) begin
        plot_command(func_i, distance_i);
      end
      rows_pending_o <= printed_rows.size();
    end
  end

endmodule

// ===== test/tb_turtle_plotter_raster_core.sv =====
`timescale 1ns / 1ps

// Drives plotter commands into the raster core with random gaps and lets the
// checker compare every printed row.
module tb_turtle_plotter_raster_core;
  import tpr_pkg::*;

  localparam int GRID          = 64;
  localparam int RANDOM_COUNT  = 260;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = GRID + 8;

  // Command codes that the block ignores.
  localparam logic [FuncW-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [FuncW-1:0] CMD_SPARE_B = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic [FuncW-1:0]    func_i;
  logic [DistW-1:0]    distance_i;
  logic                busy;
  logic                result_valid_o;
  logic [RowBitsW-1:0] row_bits_o;
  logic [RowIdxW-1:0]  row_index_o;
  logic                last_o;

  int errors;
  int rows_pending;
  int rows_checked;
  int plot_commands;
  int forward_moves;
  int prints;
  int burst_left;

  always #5 clk_i = ~clk_i;

  turtle_plotter_raster_core #(
    .GRID_SIZE(GRID)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .func_i        (func_i),
    .distance_i    (distance_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .row_bits_o    (row_bits_o),
    .row_index_o   (row_index_o),
    .last_o        (last_o)
  );

  turtle_plotter_raster_checker #(
    .GRID_SIZE(GRID)
  ) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .func_i        (func_i),
    .distance_i    (distance_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .row_bits_o    (row_bits_o),
    .row_index_o   (row_index_o),
    .last_o        (last_o),
    .errors_o      (errors),
    .rows_pending_o(rows_pending),
    .rows_checked_o(rows_checked)
  );

  // Mostly back-to-back or short gaps, now and then a long one, and bursts with none.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      burst_left = $urandom_range(8, 20);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Present one command beat, hold it until accepted, then idle for a random gap.
  task automatic send_command(input logic [FuncW-1:0] code, input logic [DistW-1:0] cells);
    int unsigned gap;
    start      <= 1'b1;
    func_i     <= code;
    distance_i <= cells;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (code != CMD_SPARE_A && code != CMD_SPARE_B) plot_commands++;
    if (code == CMD_FORWARD) forward_moves++;
    if (code == CMD_PRINT) prints++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender off until the block is idle and every printed row has come back.
  task automatic wait_for_rows();
    start <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0 || busy) @(posedge clk_i);
  endtask

  // Short moves dominate; zero and long moves up to the field maximum appear too.
  function automatic logic [DistW-1:0] pick_distance();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 70) return DistW'($urandom_range(1, 12));
    if (roll < 90) return DistW'($urandom_range(13, 63));
    return DistW'($urandom_range(0, 255));
  endfunction

  task automatic random_command();
    int unsigned roll;
    logic [DistW-1:0] noise;
    roll  = $urandom_range(0, 99);
    noise = DistW'($urandom_range(0, 255));
    if (roll < 45) send_command(CMD_FORWARD, pick_distance());
    else if (roll < 57) send_command(CMD_PEN_DOWN, noise);
    else if (roll < 65) send_command(CMD_PEN_UP, noise);
    else if (roll < 75) send_command(CMD_LEFT, noise);
    else if (roll < 85) send_command(CMD_RIGHT, noise);
    else if (roll < 91) send_command(CMD_PRINT, noise);
    else if (roll < 96) send_command(CMD_SPARE_A, noise);
    else send_command(CMD_SPARE_B, noise);
  endtask

  initial begin
    int directed_done;
    int waited;
    int total_errors;
    rst_ni        = 1'b0;
    start         = 1'b0;
    func_i        = CMD_PEN_UP;
    distance_i    = '0;
    plot_commands = 0;
    forward_moves = 0;
    prints        = 0;
    burst_left    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty print, zero moves, every edge of the grid, heading wrap
    // both ways, blocked moves, ignored codes and a final print of the drawing.
    send_command(CMD_PRINT, 8'hFF);
    send_command(CMD_FORWARD, 8'd0);
    send_command(CMD_PEN_DOWN, 8'd0);
    send_command(CMD_FORWARD, 8'd0);
    send_command(CMD_FORWARD, 8'd3);
    send_command(CMD_RIGHT, 8'd0);
    send_command(CMD_FORWARD, 8'd255);
    send_command(CMD_RIGHT, 8'd0);
    send_command(CMD_FORWARD, 8'd255);
    send_command(CMD_RIGHT, 8'd0);
    send_command(CMD_FORWARD, 8'd255);
    send_command(CMD_RIGHT, 8'd0);
    send_command(CMD_LEFT, 8'd0);
    send_command(CMD_FORWARD, 8'd5);
    send_command(CMD_PEN_UP, 8'hFF);
    send_command(CMD_LEFT, 8'd0);
    send_command(CMD_LEFT, 8'd0);
    send_command(CMD_LEFT, 8'd0);
    send_command(CMD_FORWARD, 8'h55);
    send_command(CMD_PEN_DOWN, 8'd0);
    send_command(CMD_FORWARD, 8'd1);
    send_command(CMD_SPARE_A, 8'h00);
    send_command(CMD_SPARE_B, 8'hFF);
    send_command(CMD_PRINT, 8'hAA);
    wait_for_rows();
    directed_done = plot_commands;

    // Random part, with an occasional pause until all rows are back.
    while (plot_commands - directed_done < RANDOM_COUNT) begin
      random_command();
      if ($urandom_range(0, 59) == 0) wait_for_rows();
    end

    // Let the last command finish and its rows drain, then idle before the summary.
    start <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while ((rows_pending != 0 || busy) && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    total_errors = errors + rows_pending;
    $display("Ran %0d plotter commands: %0d moves and %0d prints, %0d rows compared.",
             plot_commands, forward_moves, prints, rows_checked);
    $display("Mismatched or unexpected rows: %0d, rows never printed: %0d.",
             errors, rows_pending);
    if (total_errors == 0) begin
      $display("tb_turtle_plotter_raster_core: done, clean");
    end else begin
      $display("tb_turtle_plotter_raster_core: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("tb_turtle_plotter_raster_core: done, errors");
    $finish;
  end

endmodule

// ===== turtle_plotter_raster_core.f =====
rtl/tpr_pkg.sv
rtl/turtle_plotter_raster_core.sv
rtl/tpr_checker.sv
test/turtle_plotter_raster_checker.sv
test/tb_turtle_plotter_raster_core.sv
